>>> sv/gtcp_pkg.sv
// shared constants and types for the gpio text command parser
`default_nettype none
package gtcp_pkg;

  localparam int MAX_LINE   = 100;
  localparam int LINE_CNT_W = $clog2(MAX_LINE + 1);
  localparam int HEAD_LEN   = 4;
  localparam int HEAD_IDX_W = $clog2(HEAD_LEN);

  localparam int RX_W     = 8;
  localparam int LEVELS_W = 48;
  localparam int PORT_W   = 2;
  localparam int PIN_W    = 4;
  localparam int MODE_W   = 3;
  localparam int REPLY_W  = 6;

  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 16;

  localparam logic [RX_W-1:0] CH_A       = 8'h61;
  localparam logic [RX_W-1:0] CH_B       = 8'h62;
  localparam logic [RX_W-1:0] CH_C       = 8'h63;
  localparam logic [RX_W-1:0] CH_Z       = 8'h7a;
  localparam logic [RX_W-1:0] CH_NL      = 8'h0a;
  localparam logic [RX_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [RX_W-1:0] CH_ONE     = 8'h31;
  localparam logic [RX_W-1:0] CH_FIVE    = 8'h35;
  localparam logic [RX_W-1:0] CH_NINE    = 8'h39;
  localparam logic [RX_W-1:0] CH_QMARK   = 8'h3f;
  localparam logic [RX_W-1:0] CH_HIGH    = 8'h68;
  localparam logic [RX_W-1:0] CH_LOW     = 8'h6c;
  localparam logic [RX_W-1:0] CH_FLOAT   = 8'h66;
  localparam logic [RX_W-1:0] CH_PULLUP  = 8'h75;
  localparam logic [RX_W-1:0] CH_PULLDN  = 8'h64;
  localparam logic [RX_W-1:0] CH_STATUS  = 8'h73;

  localparam logic [REPLY_W-1:0] REPLY_BASE = 6'h30;

  typedef enum logic [PORT_W-1:0] {
    PORT_A = 2'd0,
    PORT_B = 2'd1,
    PORT_C = 2'd2
  } port_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_HIGH   = 3'd0,
    MODE_LOW    = 3'd1,
    MODE_FLOAT  = 3'd2,
    MODE_PULLUP = 3'd3,
    MODE_PULLDN = 3'd4,
    MODE_STATUS = 3'd5
  } mode_t;

  typedef struct packed {
    logic [REPLY_W-1:0] reply_byte;
    mode_t              mode;
    logic [PIN_W-1:0]   pin;
    port_t              port;
  } result_t;

endpackage
`default_nettype wire

>>> sv/gpio_text_command_parser_top.sv
// gpio text command parser: line assembly, command decode and result register
//
// s_* takes one received character per item together with the sampled pin
// levels of ports a, b and c. Bytes are ignored while enabled is 0. While the
// line is empty, characters outside a-z are dropped. The first four bytes of
// a line are kept; a newline decodes them as command letter, port letter and
// a one- or two-digit pin number. A valid line gives one m_* item holding
// port, pin, mode and the pin level as ascii '0' or '1'; bad lines give none.
// The cfg channel writes enabled and clears the line length; it is always
// ready and should be used only while the block is idle.
// The result of a newline item is in the output register in the next cycle.
// One item is taken every cycle while s_tready is high, set by the single
// decode stage in front of the output register. When the receiver stalls the
// result waits in the output register and s_tready drops only while it is
// full and not taken, so a taken result and a new item pass in the same cycle.
// Reset clears enabled, the line length and the output valid.
`default_nettype none
module gpio_text_command_parser_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic                          cfg_data,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // rx_byte [7:0], pin_levels [55:8]
  input  wire logic [gtcp_pkg::S_DATA_W-1:0] s_tdata,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // port [1:0], pin [5:2], mode [8:6], reply_byte [14:9], zero [15]
  output      logic [gtcp_pkg::M_DATA_W-1:0] m_tdata
);
  import gtcp_pkg::*;

  logic                  enabled;
  logic [LINE_CNT_W-1:0] line_count;
  logic [LINE_CNT_W-1:0] line_count_next;
  logic [RX_W-1:0]       head_bytes [HEAD_LEN];
  logic [RX_W-1:0]       head_eff   [HEAD_LEN];

  logic [RX_W-1:0]     rx_byte;
  logic [LEVELS_W-1:0] pin_levels;
  logic                s_acc;
  logic                cfg_acc;
  logic                take;
  logic                is_lower;
  logic                is_nl;
  logic                line_ok;
  logic                pin_ok;
  logic                port_ok;
  logic                mode_ok;
  logic                two_digit;
  logic [PIN_W-1:0]    pin_val;
  port_t               port_val;
  mode_t               mode_val;
  logic                level_bit;
  result_t             result;
  result_t             result_next;

  assign rx_byte    = s_tdata[RX_W-1:0];
  assign pin_levels = s_tdata[RX_W +: LEVELS_W];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign s_tready  = !m_tvalid || m_tready;
  assign s_acc     = s_tvalid && s_tready;

  assign is_lower = (rx_byte >= CH_A) && (rx_byte <= CH_Z);
  assign is_nl    = (rx_byte == CH_NL);
  // an item counts only when enabled and not a dropped leading byte
  assign take     = s_acc && enabled && ((line_count != '0) || is_lower);

  // the current byte stands in for the head entry it is about to fill
  always_comb begin
    for (int i = 0; i < HEAD_LEN; i++) begin
      head_eff[i] = (line_count == LINE_CNT_W'(i)) ? rx_byte : head_bytes[i];
    end
  end

  always_comb begin
    port_ok  = 1'b1;
    port_val = PORT_A;
    unique case (head_eff[1])
      CH_A:    port_val = PORT_A;
      CH_B:    port_val = PORT_B;
      CH_C:    port_val = PORT_C;
      default: port_ok  = 1'b0;
    endcase
  end

  always_comb begin
    mode_ok  = 1'b1;
    mode_val = MODE_HIGH;
    unique case (head_eff[0])
      CH_HIGH:   mode_val = MODE_HIGH;
      CH_LOW:    mode_val = MODE_LOW;
      CH_FLOAT:  mode_val = MODE_FLOAT;
      CH_PULLUP: mode_val = MODE_PULLUP;
      CH_PULLDN: mode_val = MODE_PULLDN;
      CH_STATUS: mode_val = MODE_STATUS;
      default:   mode_ok  = 1'b0;
    endcase
  end

  // two digits only fit when the first is 0, or 1 followed by 0-5
  assign two_digit = (line_count >= LINE_CNT_W'(3))
                  && (head_eff[3] >= CH_ZERO) && (head_eff[3] <= CH_NINE);

  always_comb begin
    pin_ok  = 1'b0;
    pin_val = '0;
    priority if (two_digit) begin
      if (head_eff[2] == CH_ZERO) begin
        pin_ok  = 1'b1;
        pin_val = PIN_W'(head_eff[3] - CH_ZERO);
      end else if ((head_eff[2] == CH_ONE) && (head_eff[3] <= CH_FIVE)) begin
        pin_ok  = 1'b1;
        pin_val = PIN_W'(head_eff[3] - CH_ZERO) + PIN_W'(10);
      end
    end else begin
      // ':' through '?' give pins 10 to 15
      if ((head_eff[2] >= CH_ZERO) && (head_eff[2] <= CH_QMARK)) begin
        pin_ok  = 1'b1;
        pin_val = PIN_W'(head_eff[2] - CH_ZERO);
      end
    end
  end

  assign line_ok   = line_count >= LINE_CNT_W'(2);
  assign level_bit = pin_levels[{port_val, pin_val}];

  always_comb begin
    result_next.port       = port_val;
    result_next.pin        = pin_val;
    result_next.mode       = mode_val;
    result_next.reply_byte = REPLY_BASE + REPLY_W'(level_bit);
  end

  always_comb begin
    line_count_next = line_count;
    if (take) begin
      if (is_nl) begin
        line_count_next = '0;
      end else if (line_count < LINE_CNT_W'(MAX_LINE)) begin
        line_count_next = line_count + LINE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      line_count <= '0;
    end else if (cfg_acc) begin
      enabled    <= cfg_data;
      line_count <= '0;
    end else begin
      line_count <= line_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (line_count < LINE_CNT_W'(HEAD_LEN))) begin
      head_bytes[line_count[HEAD_IDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= take && is_nl && line_ok && port_ok && pin_ok && mode_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      result <= result_next;
    end
  end

  assign m_tdata = {1'b0, result};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= LINE_CNT_W'(MAX_LINE))
    else $error("line length above limit");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |=> (line_count == '0))
    else $error("line length not cleared by cfg write");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (!enabled && !m_tvalid) |=> !m_tvalid)
    else $error("result while disabled");

  a_port_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((result.port != 2'd3) && (result.mode <= MODE_STATUS)))
    else $error("result port or mode out of range");

endmodule
`default_nettype wire

>>> verif/tb_gpio_text_command_parser_top.sv
// self-checking testbench for the gpio text command parser top level
`timescale 1ns / 1ps
module tb_gpio_text_command_parser_top;
  import gtcp_pkg::*;

  localparam logic [RX_W-1:0] CMD_LETTERS [6] = '{CH_HIGH, CH_LOW, CH_FLOAT,
                                                  CH_PULLUP, CH_PULLDN, CH_STATUS};
  localparam logic [RX_W-1:0] PORT_LETTERS [3] = '{CH_A, CH_B, CH_C};

  // tracks the line being assembled and the replies it should produce
  class cmd_reply_tracker;
    bit enabled;
    int unsigned line_len;
    logic [RX_W-1:0] head [HEAD_LEN];
    result_t pending_replies[$];
    int unsigned fails, replies_checked, lines_dropped;

    function void write_enable(bit v);
      enabled = v;
      line_len = 0;
    endfunction

    // returns 1 when the byte went into a line
    function bit note_byte(logic [RX_W-1:0] ch, logic [LEVELS_W-1:0] lv);
      int unsigned len;
      if (!enabled) return 0;
      if (line_len == 0 && !(ch >= CH_A && ch <= CH_Z)) return 0;
      if (line_len < HEAD_LEN) head[line_len] = ch;
      len = line_len + 1;
      if (ch == CH_NL) begin
        line_len = 0;
        decode_line(len, lv);
      end else begin
        line_len = (len > MAX_LINE) ? MAX_LINE : len;
      end
      return 1;
    endfunction

    function void decode_line(int unsigned len, logic [LEVELS_W-1:0] lv);
      result_t r;
      int pin;
      int idx;
      bit ok;
      r = '0;
      ok = (len >= 3);
      if (ok) begin
        case (head[1])
          CH_A: r.port = PORT_A;
          CH_B: r.port = PORT_B;
          CH_C: r.port = PORT_C;
          default: ok = 0;
        endcase
        // third byte is taken as a digit without checking it
        pin = int'(head[2]) - int'(CH_ZERO);
        if (len >= 4 && head[3] >= CH_ZERO && head[3] <= CH_NINE)
          pin = pin * 10 + int'(head[3]) - int'(CH_ZERO);
        if (pin < 0 || pin > (1 << PIN_W) - 1) ok = 0;
        case (head[0])
          CH_HIGH:   r.mode = MODE_HIGH;
          CH_LOW:    r.mode = MODE_LOW;
          CH_FLOAT:  r.mode = MODE_FLOAT;
          CH_PULLUP: r.mode = MODE_PULLUP;
          CH_PULLDN: r.mode = MODE_PULLDN;
          CH_STATUS: r.mode = MODE_STATUS;
          default: ok = 0;
        endcase
      end
      if (ok) begin
        r.pin = pin[PIN_W-1:0];
        idx = int'(r.port) * (1 << PIN_W) + pin;
        r.reply_byte = REPLY_BASE + REPLY_W'(lv[idx]);
        pending_replies.push_back(r);
      end else begin
        lines_dropped++;
      end
    endfunction

    function void field_mismatch(string name, int want, int got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_reply(logic [M_DATA_W-1:0] d);
      result_t want, got;
      if (pending_replies.size() == 0) begin
        $error("reply: none expected, got %h", d);
        fails++;
        return;
      end
      want = pending_replies.pop_front();
      got = result_t'(d[$bits(result_t)-1:0]);
      replies_checked++;
      field_mismatch("port", want.port, got.port);
      field_mismatch("pin", want.pin, got.pin);
      field_mismatch("mode", want.mode, got.mode);
      field_mismatch("reply_byte", want.reply_byte, got.reply_byte);
      field_mismatch("zero", 0, d[M_DATA_W-1:$bits(result_t)]);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_data = 1'b0;
  logic s_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic cfg_ready, s_tready, m_tvalid;
  logic [M_DATA_W-1:0] m_tdata;

  cmd_reply_tracker tracker = new;
  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  int unsigned line_bytes = 0;
  int unsigned stall_left = 0;

  gpio_text_command_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // receiver side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    m_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_reply(m_tdata);
  end

  function automatic logic [LEVELS_W-1:0] rand_levels();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return LEVELS_W'({$urandom, $urandom});
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_byte(input logic [RX_W-1:0] ch, input logic [LEVELS_W-1:0] lv);
    if (tx_gaps_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {lv, ch};
    do @(posedge clk); while (!s_tready);
    if (tracker.note_byte(ch, lv)) line_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic [LEVELS_W-1:0] lv);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], lv);
  endtask

  // hold the sender until every expected reply has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_enable(input bit v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_enable(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_line();
    logic [RX_W-1:0] line [$];
    logic [LEVELS_W-1:0] lv;
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    lv = rand_levels();
    if (kind < 72 || kind >= 96) begin
      // mostly well-formed command with random content
      if ($urandom_range(0, 9) == 0) line.push_back(RX_W'($urandom_range(CH_A, CH_Z)));
      else line.push_back(CMD_LETTERS[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) line.push_back(RX_W'($urandom_range(0, 255)));
      else line.push_back(PORT_LETTERS[$urandom_range(0, 2)]);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: line.push_back(CH_ZERO + RX_W'($urandom_range(0, 9)));
        5, 6: line.push_back(RX_W'($urandom_range(CH_NINE + 1, CH_QMARK)));
        7: begin
          line.push_back(CH_ONE);
          line.push_back(CH_ZERO + RX_W'($urandom_range(0, 5)));
        end
        8: begin
          line.push_back(CH_ZERO + RX_W'($urandom_range(0, 9)));
          line.push_back(CH_ZERO + RX_W'($urandom_range(0, 9)));
        end
        default: line.push_back(RX_W'($urandom_range(0, 255)));
      endcase
      n = (kind >= 98) ? $urandom_range(MAX_LINE, MAX_LINE + 10) : $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) line.push_back(CH_ZERO + RX_W'($urandom_range(0, 9)));
        else line.push_back(RX_W'($urandom_range(CH_NL + 1, 255)));
      end
      line.push_back(CH_NL);
    end else if (kind < 80) begin
      // short line
      line.push_back(RX_W'($urandom_range(CH_A, CH_Z)));
      if ($urandom_range(0, 1) == 0) line.push_back(RX_W'($urandom_range(0, 255)));
      line.push_back(CH_NL);
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 8)) line.push_back(RX_W'($urandom_range(0, 255)));
      line.push_back(CH_NL);
    end else begin
      // loose noise, possibly left as a partial line
      repeat ($urandom_range(1, 4)) line.push_back(RX_W'($urandom_range(0, 255)));
    end
    foreach (line[i]) push_byte(line[i], lv);
  endtask

  task automatic run_lines(input int unsigned target);
    while (line_bytes < target) begin
      send_random_line();
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled: nothing may come out
    write_enable(1'b0);
    send_text("ha0\n", '1);
    drain();
    write_enable(1'b1);

    push_byte(8'hff, '1);
    push_byte(CH_NL, '1);
    send_text("ha0\n", '0);
    send_text("lb15\n", '1);
    send_text("fc?\n", rand_levels());
    send_text("ub:\n", rand_levels());
    send_text("da9\n", rand_levels());
    send_text("sc7\n", rand_levels());
    drain();

    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    run_lines(650);
    drain();
    write_enable(1'b0);
    repeat (12) send_random_line();
    drain();
    write_enable(1'b1);

    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    run_lines(950);

    // a write in the middle of a line throws the partial line away
    send_text("sb", rand_levels());
    drain();
    write_enable(1'b1);
    send_text("hc5\n", rand_levels());

    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    run_lines(1400);
    send_text("la", rand_levels());
    drain();
    write_enable(1'b0);
    @(negedge clk);
    write_enable(1'b1);

    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    run_lines(1650);
    drain();
    repeat (5) @(negedge clk);

    if (tracker.pending_replies.size() != 0) begin
      $error("%0d replies never arrived", tracker.pending_replies.size());
      tracker.fails++;
    end
    $display("run covered %0d line bytes: %0d replies checked, %0d lines dropped",
             line_bytes, tracker.replies_checked, tracker.lines_dropped);
    if (tracker.fails == 0)
      $display("tb_gpio_text_command_parser_top OK");
    else
      $display("tb_gpio_text_command_parser_top NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_gpio_text_command_parser_top NOT OK");
    $finish;
  end

endmodule

>>> sim.f
sv/gtcp_pkg.sv
sv/gpio_text_command_parser_top.sv
verif/tb_gpio_text_command_parser_top.sv
